// ===== design/fsdf_pkg.sv =====
`default_nettype none

package fsdf_pkg;

  localparam int FLOW_IDX_W  = 6;
  localparam int SEQ_W       = 32;
  localparam int TIME_W      = 32;
  localparam int WIN_CFG_W   = 5;
  localparam int TIMEOUT_W   = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int FLOW_IDX_N  = 1 << FLOW_IDX_W;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_SECONDS = 2'd1;

  localparam logic [WIN_CFG_W-1:0] WINDOW_RESET  = 5'd10;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30;

  typedef struct packed {
    logic forward;
    logic cleared;
  } decision_t;

endpackage

`default_nettype wire

// ===== design/fsdf_if.sv =====
`default_nettype none

interface fsdf_pkt_if;
  import fsdf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [FLOW_IDX_W-1:0] flow_index;
  logic [SEQ_W-1:0]      sequence_number;
  logic [TIME_W-1:0]     now_seconds;
  modport source (output valid, flow_index, sequence_number, now_seconds, input ready);
  modport sink (input valid, flow_index, sequence_number, now_seconds, output ready);
endinterface

interface fsdf_res_if;
  logic valid;
  logic ready;
  logic forward;
  logic history_cleared;
  modport source (output valid, forward, history_cleared, input ready);
  modport sink (input valid, forward, history_cleared, output ready);
endinterface

interface fsdf_cfg_if;
  import fsdf_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/fsdf_ram.sv =====
`default_nettype none

module fsdf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  parameter int AW    = 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/fsdf_decide.sv =====
`default_nettype none

module fsdf_decide
  import fsdf_pkg::*;
#(
  parameter int WINDOW_MAX = 16,
  parameter int CW         = 5
) (
  input  wire logic                        flow_valid,
  input  wire logic [CW-1:0]               flow_count,
  input  wire logic [TIME_W-1:0]           flow_last,
  input  wire logic [WINDOW_MAX*SEQ_W-1:0] hist_row,
  input  wire logic [SEQ_W-1:0]            seq,
  input  wire logic [TIME_W-1:0]           now,
  input  wire logic [WIN_CFG_W-1:0]        window_length,
  input  wire logic [TIMEOUT_W-1:0]        timeout_seconds,
  output decision_t                        dec,
  output logic      [CW-1:0]               new_count,
  output logic      [WINDOW_MAX*SEQ_W-1:0] new_row
);

  logic [TIME_W-1:0]     age;
  logic                  timed_out;
  logic                  cleared;
  logic [CW-1:0]         count;
  logic [CW-1:0]         limit;
  logic [CW:0]           count_inc;
  logic [WINDOW_MAX-1:0] hit;

  always_comb begin
    age       = now - flow_last;
    timed_out = flow_valid && (age > {{(TIME_W-TIMEOUT_W){1'b0}}, timeout_seconds});
    cleared   = (seq == '0) || timed_out;
    count     = (flow_valid && !cleared) ? flow_count : '0;

    for (int i = 0; i < WINDOW_MAX; i++) begin
      hit[i] = (CW'(i) < count) && (hist_row[i*SEQ_W +: SEQ_W] == seq);
    end

    if (32'(window_length) > 32'(WINDOW_MAX)) begin
      limit = CW'(WINDOW_MAX);
    end else begin
      limit = CW'(window_length);
    end

    count_inc = {1'b0, count} + (CW+1)'(1);
    if (count_inc > {1'b0, limit}) begin
      new_count = limit;
    end else begin
      new_count = count_inc[CW-1:0];
    end

    new_row[SEQ_W-1:0] = seq;
    for (int i = 1; i < WINDOW_MAX; i++) begin
      new_row[i*SEQ_W +: SEQ_W] = hist_row[(i-1)*SEQ_W +: SEQ_W];
    end

    dec.forward = (hit == '0);
    dec.cleared = cleared;
  end

endmodule

`default_nettype wire

// ===== design/per_flow_duplicate_sequence_filter_unit.sv =====
// Per-flow duplicate sequence filter.
//
// Packets arrive on the pkt channel as a flow index, a sequence number and
// the current time in seconds; one result per packet leaves on the result
// channel telling whether the packet is forwarded and whether the flow's
// history was emptied by a zero sequence number or by timeout. The cfg
// channel writes the window length (index 0) and the timeout (index 1); it
// is always ready and should be used only while no packet is in flight.
//
// Each packet is handled in a read step and a compare step: the accepting
// cycle reads the flow's state and history row from two RAMs with registered
// reads, and the compare state then checks the whole row and, once the result
// register is free, loads the result register and writes the updated state
// and row back if the packet is forwarded. No new packet is accepted until
// the current one leaves the compare stage. A new packet is accepted while an
// earlier result waits; if the receiver still stalls when the next result is
// ready, that packet waits in the compare stage and no further packet is accepted.
//
// After reset the flow state RAM is swept clean, one flow per cycle, and no
// packet is accepted until the sweep ends; configuration writes are taken.
`default_nettype none

module per_flow_duplicate_sequence_filter_unit
  import fsdf_pkg::*;
#(
  parameter int FLOW_COUNT = 64,
  parameter int WINDOW_MAX = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  fsdf_pkt_if.sink    pkt,
  fsdf_res_if.source  result,
  fsdf_cfg_if.sink    cfg
);

  localparam int FW     = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1;
  localparam int CW     = $clog2(WINDOW_MAX + 1);
  localparam int META_W = 1 + CW + TIME_W;
  localparam int HIST_W = WINDOW_MAX * SEQ_W;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;

  logic [1:0]           state;
  logic [FW-1:0]        clr_addr;
  logic [FW-1:0]        flow_map [FLOW_IDX_N];
  logic [FW-1:0]        flow_hold;
  logic [SEQ_W-1:0]     seq_hold;
  logic [TIME_W-1:0]    now_hold;
  logic [WIN_CFG_W-1:0] window_length;
  logic [TIMEOUT_W-1:0] timeout_seconds;

  logic                 accept;
  logic                 fire;
  logic                 meta_we;
  logic [FW-1:0]        meta_waddr;
  logic [META_W-1:0]    meta_wdata;
  logic [META_W-1:0]    meta_rdata;
  logic                 hist_we;
  logic [HIST_W-1:0]    hist_rdata;
  decision_t            dec;
  logic [CW-1:0]        new_count;
  logic [HIST_W-1:0]    new_row;

  for (genvar g = 0; g < FLOW_IDX_N; g++) begin : g_map
    assign flow_map[g] = FW'(g % FLOW_COUNT);
  end

  assign pkt.ready  = (state == S_IDLE);
  assign accept     = pkt.valid && pkt.ready;
  assign fire       = (state == S_LOOK) && (!result.valid || result.ready);
  assign hist_we    = fire && dec.forward;
  assign meta_we    = (state == S_CLEAR) || hist_we;
  assign meta_waddr = (state == S_CLEAR) ? clr_addr : flow_hold;
  assign meta_wdata = (state == S_CLEAR) ? '0 : {1'b1, new_count, now_hold};
  assign cfg.ready  = 1'b1;

  fsdf_ram #(
    .WIDTH (META_W),
    .DEPTH (FLOW_COUNT),
    .AW    (FW)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (accept),
    .raddr (flow_map[pkt.flow_index]),
    .rdata (meta_rdata)
  );

  fsdf_ram #(
    .WIDTH (HIST_W),
    .DEPTH (FLOW_COUNT),
    .AW    (FW)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (flow_hold),
    .wdata (new_row),
    .re    (accept),
    .raddr (flow_map[pkt.flow_index]),
    .rdata (hist_rdata)
  );

  fsdf_decide #(
    .WINDOW_MAX (WINDOW_MAX),
    .CW         (CW)
  ) u_decide (
    .flow_valid      (meta_rdata[META_W-1]),
    .flow_count      (meta_rdata[TIME_W +: CW]),
    .flow_last       (meta_rdata[TIME_W-1:0]),
    .hist_row        (hist_rdata),
    .seq             (seq_hold),
    .now             (now_hold),
    .window_length   (window_length),
    .timeout_seconds (timeout_seconds),
    .dec             (dec),
    .new_count       (new_count),
    .new_row         (new_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + FW'(1);
          if (clr_addr == FW'(FLOW_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (fire) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      flow_hold <= flow_map[pkt.flow_index];
      seq_hold  <= pkt.sequence_number;
      now_hold  <= pkt.now_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (fire) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.forward         <= dec.forward;
      result.history_cleared <= dec.cleared;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length   <= WINDOW_RESET;
      timeout_seconds <= TIMEOUT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_WINDOW_LENGTH:   window_length   <= cfg.data[WIN_CFG_W-1:0];
        REG_TIMEOUT_SECONDS: timeout_seconds <= cfg.data[TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !pkt.ready)
    else $error("packet accepted during the clearing sweep");

  a_accept_then_look: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_LOOK) && !pkt.ready)
    else $error("accepted transaction did not enter the compare stage");

  a_drop_never_cleared: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.forward || !result.history_cleared))
    else $error("dropped packet reported a cleared history");

  a_write_only_on_forward: assert property (@(posedge clk) disable iff (rst)
    hist_we |-> (fire && dec.forward && (state == S_LOOK)))
    else $error("history row written without a forwarded packet");

endmodule

`default_nettype wire
